// ----- rtl/core/tpq_pkg.sv -----
package tpq_pkg;

    // Kind of an input word
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_TICK   = 1'b1
    } tpq_cmd_t;

    // Kind of a result word
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_NOT_DUE  = 2'd3
    } tpq_status_t;

    localparam int TSTAMP_W  = 64;
    localparam int SURFACE_W = 32;
    localparam int CLIP_W    = 16;
    localparam int FILL_W    = 5;

    // One queued frame
    typedef struct packed {
        logic [TSTAMP_W-1:0]  tstamp;
        logic [SURFACE_W-1:0] surface;
        logic [CLIP_W-1:0]    clip_w;
        logic [CLIP_W-1:0]    clip_h;
    } tpq_entry_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } tpq_cell_ctrl_t;

endpackage

// ----- rtl/core/tpq_cell.sv -----
module tpq_cell (
    input  logic                   aclk,
    input  tpq_pkg::tpq_cell_ctrl_t ctrl,
    input  logic                   occupied,
    input  tpq_pkg::tpq_entry_t    new_entry,
    input  tpq_pkg::tpq_entry_t    left_entry,
    input  logic                   left_keep,
    input  tpq_pkg::tpq_entry_t    right_entry,
    output tpq_pkg::tpq_entry_t    entry,
    output logic                   keep
);
    import tpq_pkg::*;

    tpq_entry_t entry_reg;
    tpq_entry_t entry_next;

    // Hold this entry on insert when it is due no later than the new frame
    assign keep  = occupied && (entry_reg.tstamp <= new_entry.tstamp);
    assign entry = entry_reg;

    // Hold, take the new frame, shift right on insert, or shift left on pop
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (!keep) begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/timed_presentation_queue.sv -----
// Channel | Dir | tuser                  | tdata
// s_      | in  | [0] command            | [31:0] surface_id, [47:32] clip_w,
//         |     |                        | [63:48] clip_h, [127:64] present_at,
//         |     |                        | [191:128] time_now
// m_      | out | [1:0] status           | [31:0] out_surface, [47:32] out_clip_w,
//         |     |                        | [63:48] out_clip_h, [68:64] fill_count
//
// Every cell compares its time with the new frame in parallel and the row
// shifts by one place; a new word is taken whenever s_tready is high. The
// result lands in the output register in the cycle after the word is accepted.
// s_tready is high while the output register is empty or being taken.
// Reset clears the fill count and the output valid; cell contents are left as is.
module timed_presentation_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [0:0]   s_tuser,   // [0] command
    input  logic [191:0] s_tdata,   // surface_id, clip_w, clip_h, present_at, time_now
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [1:0]   m_tuser,   // [1:0] status
    output logic [71:0]  m_tdata    // out_surface, out_clip_w, out_clip_h, fill_count
);
    import tpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [1:0]       m_user_reg;
    logic [1:0]       m_user_next;
    logic [71:0]      m_data_reg;
    logic [71:0]      m_data_next;

    tpq_entry_t       new_entry;
    logic [TSTAMP_W-1:0] time_now;
    tpq_entry_t       cell_entry [QUEUE_DEPTH];
    logic             cell_keep  [QUEUE_DEPTH];
    tpq_cell_ctrl_t   ctrl;
    logic             accept;
    logic             is_insert;
    logic             full;
    logic             due;
    logic [EXT_W-1:0] fill_ext;

    // Unpack the input word
    assign new_entry.surface = s_tdata[31:0];
    assign new_entry.clip_w  = s_tdata[47:32];
    assign new_entry.clip_h  = s_tdata[63:48];
    assign new_entry.tstamp  = s_tdata[127:64];
    assign time_now          = s_tdata[191:128];

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_insert = (s_tuser[0] == CMD_INSERT);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign due       = (count_reg != '0) && (time_now > cell_entry[0].tstamp);

    assign ctrl.ins = accept && is_insert && !full;
    assign ctrl.pop = accept && !is_insert && due;

    // Row of sorted cells, earliest frame in cell 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        tpq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .new_entry   (new_entry),
            .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
            .left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // Advance the fill count
    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign fill_ext = EXT_W'(count_next);

    // Build the result word
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_user_next  = m_user_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[68:64] = fill_ext[FILL_W-1:0];
            if (is_insert) begin
                m_user_next = full ? ST_FULL : ST_INSERTED;
            end else if (due) begin
                m_user_next        = ST_RELEASED;
                m_data_next[31:0]  = cell_entry[0].surface;
                m_data_next[47:32] = cell_entry[0].clip_w;
                m_data_next[63:48] = cell_entry[0].clip_h;
            end else begin
                m_user_next = ST_NOT_DUE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_user_reg <= m_user_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    // Fill count never passes the depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond depth");

    // The two front cells stay in time order
    a_sorted_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_entry[0].tstamp <= cell_entry[1].tstamp))
        else $error("front cells out of order");

    // A release drops the count by one and reports it
    a_release_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |=> (count_reg == $past(count_reg) - CNT_W'(1))
            && (m_user_reg == ST_RELEASED))
        else $error("release count mismatch");

    // A rejected insert leaves the count alone
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_insert && full) |=> (count_reg == $past(count_reg))
            && (m_user_reg == ST_FULL))
        else $error("rejected insert changed the queue");

endmodule
